// ----- rtl/core/pst_pkg.sv -----
// Package for the publish/subscribe table: sizes, codes, slot entry and memory port types.
// No dependencies. Compile this file first.
package pst_pkg;

    // Table geometry and field widths
    localparam int SLOT_COUNT   = 16;
    localparam int HANDLER_BITS = 16;
    localparam int ARG_BITS     = 32;
    localparam int CHAN_BITS    = 8;
    localparam int OP_BITS      = 2;
    localparam int STATUS_BITS  = 2;
    localparam int SLOT_BITS    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_BITS     = $clog2(SLOT_COUNT + 1);

    // Configuration port
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 8;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_LOWEST  = 1'b0,
        CFG_HIGHEST = 1'b1
    } cfg_idx_t;

    typedef enum logic [OP_BITS-1:0] {
        OP_SUBSCRIBE   = 2'd0,
        OP_UNSUBSCRIBE = 2'd1,
        OP_NOTIFY      = 2'd2,
        OP_RESET       = 2'd3
    } op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STAT_OK        = 2'd0,
        STAT_ILLEGAL   = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    // One slot as held in the slot memory
    typedef struct packed {
        logic [CHAN_BITS-1:0]    channel;
        logic [HANDLER_BITS-1:0] handler;
        logic [ARG_BITS-1:0]     arg;
    } slot_entry_t;

    // Request bundle from the controller to the slot memory
    typedef struct packed {
        logic                 we;
        logic [SLOT_BITS-1:0] waddr;
        slot_entry_t          wdata;
        logic                 re;
        logic [SLOT_BITS-1:0] raddr;
    } mem_req_t;

endpackage

// ----- rtl/core/pst_if.sv -----
// Valid/ready channel interfaces for requests and results of the publish/subscribe table.
// Depends on pst_pkg.
interface pst_req_if import pst_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [OP_BITS-1:0]      operation;
    logic [CHAN_BITS-1:0]    channel;
    logic [HANDLER_BITS-1:0] handler_id;
    logic [ARG_BITS-1:0]     subscriber_arg;
    logic [ARG_BITS-1:0]     event_arg;

    modport source (output valid, operation, channel, handler_id, subscriber_arg, event_arg,
                    input ready);
    modport sink   (input valid, operation, channel, handler_id, subscriber_arg, event_arg,
                    output ready);
endinterface

interface pst_rsp_if import pst_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [STATUS_BITS-1:0]  status;
    logic                    is_delivery;
    logic [CHAN_BITS-1:0]    out_channel;
    logic [HANDLER_BITS-1:0] out_handler;
    logic [ARG_BITS-1:0]     out_event_arg;
    logic [ARG_BITS-1:0]     out_subscriber_arg;
    logic                    last;

    modport source (output valid, status, is_delivery, out_channel, out_handler,
                    out_event_arg, out_subscriber_arg, last,
                    input ready);
    modport sink   (input valid, status, is_delivery, out_channel, out_handler,
                    out_event_arg, out_subscriber_arg, last,
                    output ready);
endinterface

// ----- rtl/core/pst_slot_mem.sv -----
// Slot storage: channel, handler and argument of every slot, one write and one read port.
// Read data is registered and holds while no read is issued.
// Depends on pst_pkg.
module pst_slot_mem import pst_pkg::*;
(
    input  logic        clk,
    input  mem_req_t    mreq,
    output slot_entry_t rdata
);

    slot_entry_t mem [SLOT_COUNT];
    slot_entry_t rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (mreq.we)
        begin
            mem[mreq.waddr] <= mreq.wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (mreq.re)
        begin
            rdata_reg <= mem[mreq.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/publish_subscribe_table.sv -----
// Top level of the publish/subscribe table: sequencer, valid bits, config and result register.
// Depends on pst_pkg, pst_req_if/pst_rsp_if and pst_slot_mem.
//
//  port   | dir | kind          | carries
//  -------+-----+---------------+--------------------------------------------------
//  req    | in  | valid/ready   | operation, channel, handler_id, args
//  rsp    | out | valid/ready   | deliveries then one status result (last = 1)
//  cfg_*  | in  | write only    | lowest_channel (index 0), highest_channel (index 1)
//
// Legal subscribe and notify, and every unsubscribe, walk all SLOT_COUNT slots through the
// slot memory read port, one slot per cycle while no delivery stalls, then finish in S_DONE.
// Table reset and illegal channels go straight to S_DONE. A stalled result register holds
// the scan on a pending delivery.
// Reset clears all valid bits at once; the slot memory itself needs no clearing.
module publish_subscribe_table import pst_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    pst_req_if.sink                   req,
    pst_rsp_if.source                 rsp
);

    // Control state
    state_t                  state_reg, state_next;
    op_t                     op_reg, op_next;
    logic                    illegal_reg, illegal_next;
    logic [CNT_BITS-1:0]     rd_cnt_reg, rd_cnt_next;
    logic                    cmp_valid_reg, cmp_valid_next;
    logic [SLOT_BITS-1:0]    cmp_idx_reg, cmp_idx_next;
    logic                    hit_found_reg, hit_found_next;
    logic [SLOT_BITS-1:0]    hit_idx_reg, hit_idx_next;
    logic                    free_found_reg, free_found_next;
    logic [SLOT_BITS-1:0]    free_idx_reg, free_idx_next;
    logic [SLOT_COUNT-1:0]   valid_reg, valid_next;
    logic [CHAN_BITS-1:0]    low_reg, high_reg;
    logic                    out_valid_reg, out_valid_next;

    // Item payload
    logic [CHAN_BITS-1:0]    ch_reg, ch_next;
    logic [HANDLER_BITS-1:0] h_reg, h_next;
    logic [ARG_BITS-1:0]     sarg_reg, sarg_next;
    logic [ARG_BITS-1:0]     earg_reg, earg_next;

    // Result payload
    status_t                 out_status_reg, out_status_next;
    logic                    out_deliv_reg, out_deliv_next;
    logic [CHAN_BITS-1:0]    out_ch_reg, out_ch_next;
    logic [HANDLER_BITS-1:0] out_h_reg, out_h_next;
    logic [ARG_BITS-1:0]     out_earg_reg, out_earg_next;
    logic [ARG_BITS-1:0]     out_sarg_reg, out_sarg_next;
    logic                    out_last_reg, out_last_next;

    mem_req_t                mreq;
    slot_entry_t             rdata;

    logic                    accept;
    logic                    legal;
    logic                    out_free;
    logic                    cmp_match;
    logic                    stall;
    logic                    issue;
    logic                    scan_end;
    op_t                     req_op;

    pst_slot_mem u_slot_mem
    (
        .clk   (clk),
        .mreq  (mreq),
        .rdata (rdata)
    );

    // Handshake and scan qualifiers
    assign req_op    = op_t'(req.operation);
    assign accept    = req.valid && req.ready;
    assign legal     = (req.channel >= low_reg) && (req.channel <= high_reg);
    assign out_free  = !out_valid_reg || rsp.ready;
    assign cmp_match = valid_reg[cmp_idx_reg] && (rdata.channel == ch_reg)
                       && ((op_reg == OP_NOTIFY) || (rdata.handler == h_reg));
    assign stall     = cmp_valid_reg && (op_reg == OP_NOTIFY) && cmp_match && !out_free;
    assign issue     = (rd_cnt_reg < CNT_BITS'(SLOT_COUNT));
    assign scan_end  = !issue && !stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if ((req_op == OP_UNSUBSCRIBE)
                        || (((req_op == OP_SUBSCRIBE) || (req_op == OP_NOTIFY)) && legal))
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath control, memory requests and result loading
    always_comb
    begin
        req.ready       = 1'b0;
        mreq            = '0;
        op_next         = op_reg;
        illegal_next    = illegal_reg;
        rd_cnt_next     = rd_cnt_reg;
        cmp_valid_next  = cmp_valid_reg;
        cmp_idx_next    = cmp_idx_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        valid_next      = valid_reg;
        ch_next         = ch_reg;
        h_next          = h_reg;
        sarg_next       = sarg_reg;
        earg_next       = earg_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_deliv_next  = out_deliv_reg;
        out_ch_next     = out_ch_reg;
        out_h_next      = out_h_reg;
        out_earg_next   = out_earg_reg;
        out_sarg_next   = out_sarg_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (accept)
                begin
                    op_next         = req_op;
                    ch_next         = req.channel;
                    h_next          = req.handler_id;
                    sarg_next       = req.subscriber_arg;
                    earg_next       = req.event_arg;
                    illegal_next    = !legal
                                      && ((req_op == OP_SUBSCRIBE) || (req_op == OP_NOTIFY));
                    rd_cnt_next     = '0;
                    cmp_valid_next  = 1'b0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                end
            end
            S_SCAN:
            begin
                if (!stall)
                begin
                    // read stage: next slot
                    cmp_valid_next = issue;
                    cmp_idx_next   = rd_cnt_reg[SLOT_BITS-1:0];
                    if (issue)
                    begin
                        mreq.re     = 1'b1;
                        mreq.raddr  = rd_cnt_reg[SLOT_BITS-1:0];
                        rd_cnt_next = rd_cnt_reg + CNT_BITS'(1);
                    end
                    // compare stage: slot fetched by the read stage
                    if (cmp_valid_reg)
                    begin
                        if (cmp_match && !hit_found_reg)
                        begin
                            hit_found_next = 1'b1;
                            hit_idx_next   = cmp_idx_reg;
                        end
                        if (!valid_reg[cmp_idx_reg] && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = cmp_idx_reg;
                        end
                        if (cmp_match && (op_reg == OP_NOTIFY))
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = STAT_OK;
                            out_deliv_next  = 1'b1;
                            out_ch_next     = ch_reg;
                            out_h_next      = rdata.handler;
                            out_earg_next   = earg_reg;
                            out_sarg_next   = rdata.arg;
                            out_last_next   = 1'b0;
                        end
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_OK;
                    out_deliv_next  = 1'b0;
                    out_ch_next     = '0;
                    out_h_next      = '0;
                    out_earg_next   = '0;
                    out_sarg_next   = '0;
                    out_last_next   = 1'b1;
                    mreq.wdata.channel = ch_reg;
                    mreq.wdata.handler = h_reg;
                    mreq.wdata.arg     = sarg_reg;
                    case (op_reg)
                        OP_SUBSCRIBE:
                        begin
                            if (illegal_reg)
                            begin
                                out_status_next = STAT_ILLEGAL;
                            end
                            else if (hit_found_reg)
                            begin
                                // same pair already present: refresh its argument
                                mreq.we    = 1'b1;
                                mreq.waddr = hit_idx_reg;
                            end
                            else if (free_found_reg)
                            begin
                                mreq.we                 = 1'b1;
                                mreq.waddr              = free_idx_reg;
                                valid_next[free_idx_reg] = 1'b1;
                            end
                            else
                            begin
                                out_status_next = STAT_FULL;
                            end
                        end
                        OP_UNSUBSCRIBE:
                        begin
                            if (hit_found_reg)
                            begin
                                valid_next[hit_idx_reg] = 1'b0;
                            end
                            else
                            begin
                                out_status_next = STAT_NOT_FOUND;
                            end
                        end
                        OP_NOTIFY:
                        begin
                            if (illegal_reg)
                            begin
                                out_status_next = STAT_ILLEGAL;
                            end
                        end
                        OP_RESET:
                        begin
                            valid_next = '0;
                        end
                        default:
                        begin
                            out_status_next = STAT_OK;
                        end
                    endcase
                end
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_SUBSCRIBE;
            illegal_reg    <= 1'b0;
            rd_cnt_reg     <= '0;
            cmp_valid_reg  <= 1'b0;
            cmp_idx_reg    <= '0;
            hit_found_reg  <= 1'b0;
            hit_idx_reg    <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            illegal_reg    <= illegal_next;
            rd_cnt_reg     <= rd_cnt_next;
            cmp_valid_reg  <= cmp_valid_next;
            cmp_idx_reg    <= cmp_idx_next;
            hit_found_reg  <= hit_found_next;
            hit_idx_reg    <= hit_idx_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            valid_reg      <= valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Channel range registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= '0;
            high_reg <= '1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LOWEST:  low_reg  <= cfg_data;
                CFG_HIGHEST: high_reg <= cfg_data;
                default:     low_reg  <= low_reg;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ch_reg         <= ch_next;
        h_reg          <= h_next;
        sarg_reg       <= sarg_next;
        earg_reg       <= earg_next;
        out_status_reg <= out_status_next;
        out_deliv_reg  <= out_deliv_next;
        out_ch_reg     <= out_ch_next;
        out_h_reg      <= out_h_next;
        out_earg_reg   <= out_earg_next;
        out_sarg_reg   <= out_sarg_next;
        out_last_reg   <= out_last_next;
    end

    // Result channel
    assign rsp.valid              = out_valid_reg;
    assign rsp.status             = out_status_reg;
    assign rsp.is_delivery        = out_deliv_reg;
    assign rsp.out_channel        = out_ch_reg;
    assign rsp.out_handler        = out_h_reg;
    assign rsp.out_event_arg      = out_earg_reg;
    assign rsp.out_subscriber_arg = out_sarg_reg;
    assign rsp.last               = out_last_reg;

endmodule

// ----- sim/tb_publish_subscribe_table.sv -----
`timescale 1ns / 100ps
// Testbench for publish_subscribe_table: directed and random subscribe, unsubscribe, notify
// and table-reset traffic, every result checked against a slot-table scoreboard.
// Depends on pst_pkg, pst_req_if/pst_rsp_if and the publish_subscribe_table RTL.
module tb_publish_subscribe_table import pst_pkg::*;;

    localparam int IDLE_LIMIT    = 3000;  // cycles with no transfer before giving up
    localparam int SETTLE_CYCLES = 40;    // scan latency plus margin

    typedef struct {
        op_t                   op;
        bit [CHAN_BITS-1:0]    channel;
        bit [HANDLER_BITS-1:0] handler;
        bit [ARG_BITS-1:0]     sub_arg;
        bit [ARG_BITS-1:0]     ev_arg;
    } table_request_t;

    typedef struct {
        status_t               status;
        bit                    is_delivery;
        bit [CHAN_BITS-1:0]    channel;
        bit [HANDLER_BITS-1:0] handler;
        bit [ARG_BITS-1:0]     ev_arg;
        bit [ARG_BITS-1:0]     sub_arg;
        bit                    last;
    } table_result_t;

    // Scoreboard: shadow copy of the slot table and the results it owes
    class slot_table_scoreboard;
        bit                    occupied     [SLOT_COUNT];
        bit [CHAN_BITS-1:0]    slot_chan    [SLOT_COUNT];
        bit [HANDLER_BITS-1:0] slot_handler [SLOT_COUNT];
        bit [ARG_BITS-1:0]     slot_arg     [SLOT_COUNT];
        bit [CHAN_BITS-1:0]    chan_low;
        bit [CHAN_BITS-1:0]    chan_high;
        table_result_t         owed_results [$];
        int                    mismatches;
        int                    results_seen;
        int                    deliveries_seen;

        function new();
            occupied        = '{default: 1'b0};
            chan_low        = '0;
            chan_high       = '1;
            mismatches      = 0;
            results_seen    = 0;
            deliveries_seen = 0;
        endfunction

        function void set_range(bit [CHAN_BITS-1:0] lo, bit [CHAN_BITS-1:0] hi);
            chan_low  = lo;
            chan_high = hi;
        endfunction

        function bit channel_legal(bit [CHAN_BITS-1:0] ch);
            return (ch >= chan_low) && (ch <= chan_high);
        endfunction

        // first occupied slot holding this channel/handler pair, -1 if none
        function int find_subscription(bit [CHAN_BITS-1:0] ch, bit [HANDLER_BITS-1:0] h);
            for (int i = 0; i < SLOT_COUNT; i++)
                if (occupied[i] && slot_chan[i] == ch && slot_handler[i] == h)
                    return i;
            return -1;
        endfunction

        // random live subscription, for unsubscribes that hit
        function bit pick_subscription(output bit [CHAN_BITS-1:0] ch,
                                       output bit [HANDLER_BITS-1:0] h);
            int live [$];
            int k;
            for (int i = 0; i < SLOT_COUNT; i++)
                if (occupied[i])
                    live.push_back(i);
            if (live.size() == 0)
                return 1'b0;
            k  = live[$urandom_range(0, live.size() - 1)];
            ch = slot_chan[k];
            h  = slot_handler[k];
            return 1'b1;
        endfunction

        // apply one accepted request and queue the results it causes
        function void note_request(table_request_t rq);
            int            hit;
            int            free_slot;
            status_t       st;
            table_result_t res;
            st  = STAT_OK;
            res = '{status: STAT_OK, is_delivery: 1'b1, channel: rq.channel, handler: '0,
                    ev_arg: rq.ev_arg, sub_arg: '0, last: 1'b0};
            case (rq.op)
                OP_SUBSCRIBE:
                begin
                    if (!channel_legal(rq.channel))
                        st = STAT_ILLEGAL;
                    else
                    begin
                        hit = find_subscription(rq.channel, rq.handler);
                        if (hit >= 0)
                            slot_arg[hit] = rq.sub_arg;
                        else
                        begin
                            free_slot = -1;
                            for (int i = 0; i < SLOT_COUNT && free_slot < 0; i++)
                                if (!occupied[i])
                                    free_slot = i;
                            if (free_slot < 0)
                                st = STAT_FULL;
                            else
                            begin
                                occupied[free_slot]     = 1'b1;
                                slot_chan[free_slot]    = rq.channel;
                                slot_handler[free_slot] = rq.handler;
                                slot_arg[free_slot]     = rq.sub_arg;
                            end
                        end
                    end
                end
                OP_UNSUBSCRIBE:
                begin
                    // no legality check on unsubscribe
                    hit = find_subscription(rq.channel, rq.handler);
                    if (hit >= 0)
                        occupied[hit] = 1'b0;
                    else
                        st = STAT_NOT_FOUND;
                end
                OP_NOTIFY:
                begin
                    if (!channel_legal(rq.channel))
                        st = STAT_ILLEGAL;
                    else
                        for (int i = 0; i < SLOT_COUNT; i++)
                            if (occupied[i] && slot_chan[i] == rq.channel)
                            begin
                                res.handler = slot_handler[i];
                                res.sub_arg = slot_arg[i];
                                owed_results.push_back(res);
                            end
                end
                default:
                    occupied = '{default: 1'b0};
            endcase
            // closing status transfer
            res = '{status: st, is_delivery: 1'b0, channel: '0, handler: '0,
                    ev_arg: '0, sub_arg: '0, last: 1'b1};
            owed_results.push_back(res);
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want != got)
            begin
                $error("%s mismatch: expected %0h, got %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(table_result_t got);
            table_result_t want;
            results_seen++;
            if (owed_results.size() == 0)
            begin
                $error("result with nothing expected: status %0d delivery %0b handler %0h",
                       got.status, got.is_delivery, got.handler);
                mismatches++;
                return;
            end
            want = owed_results.pop_front();
            if (want.is_delivery)
                deliveries_seen++;
            compare_field("status", want.status, got.status);
            compare_field("is_delivery", want.is_delivery, got.is_delivery);
            compare_field("out_channel", want.channel, got.channel);
            compare_field("out_handler", want.handler, got.handler);
            compare_field("out_event_arg", want.ev_arg, got.ev_arg);
            compare_field("out_subscriber_arg", want.sub_arg, got.sub_arg);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    pst_req_if req_ch ();
    pst_rsp_if rsp_ch ();

    publish_subscribe_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    slot_table_scoreboard table_sb = new();
    bit                   req_calm;
    bit                   rsp_calm;
    int                   op_count [4];

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int draw_wait(bit calm);
        return calm ? 0 : $urandom_range(0, 4);
    endfunction

    // Present one request, hold until the transfer, then maybe drop valid for a gap
    task automatic send_request(input table_request_t rq);
        int gap;
        req_ch.valid          <= 1'b1;
        req_ch.operation      <= rq.op;
        req_ch.channel        <= rq.channel;
        req_ch.handler_id     <= rq.handler;
        req_ch.subscriber_arg <= rq.sub_arg;
        req_ch.event_arg      <= rq.ev_arg;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        table_sb.note_request(rq);
        op_count[rq.op]++;
        gap = draw_wait(req_calm);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic issue(input op_t op, input bit [CHAN_BITS-1:0] ch,
                         input bit [HANDLER_BITS-1:0] h, input bit [ARG_BITS-1:0] sa,
                         input bit [ARG_BITS-1:0] ea);
        table_request_t rq;
        rq = '{op: op, channel: ch, handler: h, sub_arg: sa, ev_arg: ea};
        send_request(rq);
    endtask

    // Both registers, back to back; only called while the table is idle
    task automatic write_range(input bit [CFG_DATA_BITS-1:0] lo,
                               input bit [CFG_DATA_BITS-1:0] hi);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LOWEST;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= CFG_HIGHEST;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_we    <= 1'b0;
        table_sb.set_range(lo, hi);
    endtask

    // Drop valid, drain every owed result, then let the sequencer settle
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (table_sb.owed_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly a small pool of channels around the legal window and a few handlers,
    // so the table fills, updates and empties; the rest is full-range noise
    function automatic table_request_t random_request(bit [CHAN_BITS-1:0] lo,
                                                      bit [CHAN_BITS-1:0] hi);
        table_request_t     rq;
        bit [CHAN_BITS-1:0] pool [4];
        int                 pick;
        pool[0] = lo;
        pool[1] = hi;
        pool[2] = lo + (hi - lo) / 2;
        pool[3] = hi + 8'd1;
        pick    = $urandom_range(0, 99);
        if (pick < 44)
            rq.op = OP_SUBSCRIBE;
        else if (pick < 70)
            rq.op = OP_UNSUBSCRIBE;
        else if (pick < 98)
            rq.op = OP_NOTIFY;
        else
            rq.op = OP_RESET;
        rq.channel = ($urandom_range(0, 4) == 0) ? CHAN_BITS'($urandom)
                                                 : pool[$urandom_range(0, 3)];
        rq.handler = ($urandom_range(0, 4) == 0) ? HANDLER_BITS'($urandom_range(1, 65535))
                                                 : HANDLER_BITS'($urandom_range(1, 6));
        rq.sub_arg = $urandom;
        rq.ev_arg  = $urandom;
        if (rq.op == OP_UNSUBSCRIBE && $urandom_range(0, 9) < 6)
            void'(table_sb.pick_subscription(rq.channel, rq.handler));
        return rq;
    endfunction

    task automatic run_random_phase(input bit [CHAN_BITS-1:0] lo, input bit [CHAN_BITS-1:0] hi,
                                    input int items, input bit calm_req, input bit calm_rsp);
        wait_idle();
        req_calm = calm_req;
        rsp_calm = calm_rsp;
        write_range(lo, hi);
        repeat (items) send_request(random_request(lo, hi));
    endtask

    // Result side: random stalls, check each transfer
    initial
    begin : result_sink
        table_result_t got;
        int            stall;
        forever
        begin
            stall = draw_wait(rsp_calm);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (rsp_ch.valid !== 1'b1);
            got.status      = status_t'(rsp_ch.status);
            got.is_delivery = rsp_ch.is_delivery;
            got.channel     = rsp_ch.out_channel;
            got.handler     = rsp_ch.out_handler;
            got.ev_arg      = rsp_ch.out_event_arg;
            got.sub_arg     = rsp_ch.out_subscriber_arg;
            got.last        = rsp_ch.last;
            table_sb.check_result(got);
        end
    end

    // Watchdog on cycles without any transfer
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) === 1'b1
                || (rsp_ch.valid && rsp_ch.ready) === 1'b1)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $error("no transfer for %0d cycles, %0d results still owed", IDLE_LIMIT,
               table_sb.owed_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // Main sequence
    initial
    begin : stimulus
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_index             <= CFG_LOWEST;
        cfg_data              <= '0;
        req_ch.valid          <= 1'b0;
        req_ch.operation      <= OP_NOTIFY;
        req_ch.channel        <= '0;
        req_ch.handler_id     <= '0;
        req_ch.subscriber_arg <= '0;
        req_ch.event_arg      <= '0;
        req_calm = 1'b0;
        rsp_calm = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_range(8'd0, 8'd255);

        // directed: empty notify, extremes, argument update, misses, handler zero
        issue(OP_NOTIFY,      8'd0,   16'h0001, 32'h0,         32'h0);
        issue(OP_SUBSCRIBE,   8'd0,   16'h0001, 32'h0,         32'h0);
        issue(OP_SUBSCRIBE,   8'd255, 16'hFFFF, 32'hFFFF_FFFF, 32'h0);
        issue(OP_SUBSCRIBE,   8'd0,   16'h0001, 32'hA5A5_5A5A, 32'h0);
        issue(OP_NOTIFY,      8'd0,   16'h0001, 32'h0,         32'hFFFF_FFFF);
        issue(OP_UNSUBSCRIBE, 8'd255, 16'h0001, 32'h0,         32'h0);
        issue(OP_SUBSCRIBE,   8'd9,   16'h0000, 32'h1234_5678, 32'h0);
        issue(OP_NOTIFY,      8'd9,   16'h0000, 32'h0,         32'h0000_0005);
        issue(OP_UNSUBSCRIBE, 8'd9,   16'h0000, 32'h0,         32'h0);
        // fill the table, overflow it, fan a notify out, then clear it
        for (int i = 0; i < SLOT_COUNT - 2; i++)
            issue(OP_SUBSCRIBE, 8'd9, 16'h0010 + HANDLER_BITS'(i), $urandom, 32'h0);
        issue(OP_SUBSCRIBE,   8'd9,   16'h7777, 32'h0,         32'h0);
        issue(OP_NOTIFY,      8'd9,   16'h0001, 32'h0,         32'hFFFF_FFFF);
        issue(OP_RESET,       8'd0,   16'h0001, 32'h0,         32'h0);
        issue(OP_NOTIFY,      8'd9,   16'h0001, 32'h0,         32'hDEAD_0001);

        // random phases over several legal windows; the table carries across them
        run_random_phase(8'd0,   8'd255, 30, 1'b0, 1'b0);
        run_random_phase(8'd20,  8'd40,  30, 1'b1, 1'b0);
        run_random_phase(8'd255, 8'd0,   15, 1'b0, 1'b1);
        run_random_phase(8'd128, 8'd128, 20, 1'b0, 1'b0);
        run_random_phase(8'd0,   8'd255, 28, 1'b1, 1'b1);
        wait_idle();

        $display("Run covered %0d subscribe, %0d unsubscribe, %0d notify and %0d table reset",
                 op_count[OP_SUBSCRIBE], op_count[OP_UNSUBSCRIBE], op_count[OP_NOTIFY],
                 op_count[OP_RESET]);
        $display("requests over six channel windows; %0d results checked, %0d deliveries.",
                 table_sb.results_seen, table_sb.deliveries_seen);
        if (table_sb.mismatches == 0 && table_sb.owed_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
